[hdl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// ced_pkg : shared types and constants for the edit distance engine
// Mode codes, controller states, widths and the ASCII case fold.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int CHAR_W        = 8;
    localparam int MODE_W        = 2;
    localparam int DIST_W        = 7;
    localparam int TOO_LONG_DIST = 99;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_FINISH = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WAIT,
        ST_DONE
    } state_t;

    // fold ASCII 'A'..'Z' onto 'a'..'z', other bytes unchanged
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[hdl/ced_feed.sv]
// ----------------------------------------------------------------------------
// ced_feed : first string store and row feeder
// Holds the first string and streams one row character per cycle into the
// head of the cell chain, together with the column-zero table values.
// ----------------------------------------------------------------------------
module ced_feed #(
    parameter int MAX_LEN = 64,
    parameter int LW      = 7,
    parameter int AW      = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [ced_pkg::CHAR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    input  logic                       rd_last,
    input  logic [LW-1:0]              rd_row,
    output logic [ced_pkg::CHAR_W-1:0] a_out,
    output logic                       v_out,
    output logic                       last_out,
    output logic [LW-1:0]              dn_out,
    output logic [LW-1:0]              do_out
);
    import ced_pkg::*;

    logic [CHAR_W-1:0] mem [0:MAX_LEN-1];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              v_reg;
    logic              last_reg;
    logic [LW-1:0]     row_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        row_reg     <= rd_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            v_reg    <= rd_en;
            last_reg <= rd_en && rd_last;
        end
    end

    // column zero: D[i][0] = i, D[i-1][0] = i-1
    assign a_out    = fold_case(rd_data_reg);
    assign v_out    = v_reg;
    assign last_out = last_reg;
    assign dn_out   = row_reg;
    assign do_out   = row_reg - LW'(1);

endmodule

[hdl/ced_cell.sv]
// ----------------------------------------------------------------------------
// ced_cell : one column of the edit distance table
// Holds one folded character of the second string and the latest table
// value of its column; rows pass through as a diagonal wavefront.
// ----------------------------------------------------------------------------
module ced_cell #(
    parameter int LW  = 7,
    parameter int COL = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       init,
    input  logic                       load_en,
    input  logic [ced_pkg::CHAR_W-1:0] load_ch,
    input  logic [LW-1:0]              len,
    input  logic [ced_pkg::CHAR_W-1:0] a_in,
    input  logic                       v_in,
    input  logic                       last_in,
    input  logic [LW-1:0]              dn_in,
    input  logic [LW-1:0]              do_in,
    input  logic                       res_v_in,
    input  logic [LW-1:0]              res_d_in,
    output logic [ced_pkg::CHAR_W-1:0] a_out,
    output logic                       v_out,
    output logic                       last_out,
    output logic [LW-1:0]              dn_out,
    output logic [LW-1:0]              do_out,
    output logic                       res_v_out,
    output logic [LW-1:0]              res_d_out
);
    import ced_pkg::*;

    logic [CHAR_W-1:0] b_reg;
    logic [CHAR_W-1:0] a_reg;
    logic              v_reg, v_next;
    logic              last_reg, last_next;
    logic [LW-1:0]     d_reg, d_next;
    logic [LW-1:0]     dp_reg, dp_next;
    logic              res_v_reg, res_v_next;
    logic [LW-1:0]     res_d_reg, res_d_next;

    logic [LW:0] up_w, left_w, diag_w, best_w;
    logic        is_end;

    assign is_end = (len == LW'(COL));

    always_comb begin
        up_w   = {1'b0, d_reg} + (LW+1)'(1);
        left_w = {1'b0, dn_in} + (LW+1)'(1);
        diag_w = {1'b0, do_in} + ((a_in != b_reg) ? (LW+1)'(1) : (LW+1)'(0));
        best_w = up_w;
        if (left_w < best_w) begin
            best_w = left_w;
        end
        if (diag_w < best_w) begin
            best_w = diag_w;
        end

        v_next     = v_in;
        last_next  = last_in;
        d_next     = d_reg;
        dp_next    = dp_reg;
        res_v_next = res_v_in;
        res_d_next = res_d_in;
        if (init) begin
            v_next     = 1'b0;
            last_next  = 1'b0;
            d_next     = LW'(COL);
            res_v_next = 1'b0;
        end else if (v_in) begin
            d_next  = best_w[LW-1:0];
            dp_next = d_reg;
            // last row reaching the end column: launch the result downstream
            if (last_in && is_end) begin
                res_v_next = 1'b1;
                res_d_next = best_w[LW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= 1'b0;
            last_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end else begin
            v_reg     <= v_next;
            last_reg  <= last_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && len == LW'(COL-1)) begin
            b_reg <= fold_case(load_ch);
        end
        a_reg     <= a_in;
        d_reg     <= d_next;
        dp_reg    <= dp_next;
        res_d_reg <= res_d_next;
    end

    assign a_out     = a_reg;
    assign v_out     = v_reg;
    assign last_out  = last_reg;
    assign dn_out    = d_reg;
    assign do_out    = dp_reg;
    assign res_v_out = res_v_reg;
    assign res_d_out = res_d_reg;

endmodule

[hdl/case_insensitive_edit_distance_top.sv]
// ----------------------------------------------------------------------------
// case_insensitive_edit_distance_top : Levenshtein distance engine
// Append transfers are accepted back to back.
// A finish with an empty string or an overflow goes straight to ST_DONE.
// Otherwise the result waits for one feeder read per row, after which the
// wavefront and result ripple through MAX_LEN cells; the next transfer is
// taken once the controller is back in ST_IDLE.
// A stalled result register holds the controller in ST_DONE until it drains.
// Synchronous active-low reset clears lengths, overflow flag and all valids.
// ----------------------------------------------------------------------------
module case_insensitive_edit_distance_top #(
    parameter int MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [1:0] s_tuser,   // [1:0] mode
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] distance, [7] zero pad
    output logic       m_tuser    // [0] too_long
);
    import ced_pkg::*;

    // length counters hold 0..MAX_LEN; store index 0..MAX_LEN-1
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = (LW > DIST_W) ? LW : DIST_W;

    // clamp a table value to TOO_LONG_DIST for the 7-bit result
    function automatic logic [DIST_W-1:0] sat_dist(input logic [LW-1:0] x);
        logic [CW-1:0] e;
        e = CW'(x);
        return (e > CW'(TOO_LONG_DIST)) ? DIST_W'(TOO_LONG_DIST) : e[DIST_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [LW-1:0]     first_len_reg, first_len_next;
    logic [LW-1:0]     second_len_reg, second_len_next;
    logic              ovf_reg, ovf_next;
    logic [LW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [DIST_W-1:0] pend_d_reg, pend_d_next;
    logic              pend_f_reg, pend_f_next;
    logic              m_valid_reg, m_valid_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;
    logic              m_flag_reg, m_flag_next;

    logic  s_acc;
    mode_t s_mode;
    logic  mem_wr, rd_en, rd_last, cell_init, cell_load;

    // chain links, index 0 is the feeder, index MAX_LEN the tail cell
    logic [CHAR_W-1:0] a_w     [0:MAX_LEN];
    logic              v_w     [0:MAX_LEN];
    logic              last_w  [0:MAX_LEN];
    logic [LW-1:0]     dn_w    [0:MAX_LEN];
    logic [LW-1:0]     do_w    [0:MAX_LEN];
    logic              res_v_w [0:MAX_LEN];
    logic [LW-1:0]     res_d_w [0:MAX_LEN];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign s_mode   = mode_t'(s_tuser);

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_d_next     = pend_d_reg;
        pend_f_next     = pend_f_reg;
        m_valid_next    = m_valid_reg;
        m_dist_next     = m_dist_reg;
        m_flag_next     = m_flag_reg;
        mem_wr          = 1'b0;
        rd_en           = 1'b0;
        rd_last         = 1'b0;
        cell_init       = 1'b0;
        cell_load       = 1'b0;

        // output register drains independently of the controller
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_mode)
                        MODE_FIRST: begin
                            if (first_len_reg < LW'(MAX_LEN)) begin
                                mem_wr         = 1'b1;
                                first_len_next = first_len_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_SECOND: begin
                            if (second_len_reg < LW'(MAX_LEN)) begin
                                cell_load       = 1'b1;
                                second_len_next = second_len_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_FINISH: begin
                            priority if (ovf_reg) begin
                                pend_d_next = DIST_W'(TOO_LONG_DIST);
                                pend_f_next = 1'b1;
                                state_next  = ST_DONE;
                            end else if (first_len_reg == '0) begin
                                // empty first string: distance is the other length
                                pend_d_next = sat_dist(second_len_reg);
                                pend_f_next = 1'b0;
                                state_next  = ST_DONE;
                            end else if (second_len_reg == '0) begin
                                pend_d_next = sat_dist(first_len_reg);
                                pend_f_next = 1'b0;
                                state_next  = ST_DONE;
                            end else begin
                                cell_init   = 1'b1;
                                rd_cnt_next = '0;
                                state_next  = ST_SWEEP;
                            end
                        end
                        default: begin
                            // unused mode: transfer taken, nothing changes
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // one row of the table enters the chain per cycle
                rd_en       = 1'b1;
                rd_last     = (rd_cnt_reg == first_len_reg - LW'(1));
                rd_cnt_next = rd_cnt_reg + LW'(1);
                if (rd_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res_v_w[MAX_LEN]) begin
                    pend_d_next = sat_dist(res_d_w[MAX_LEN]);
                    pend_f_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    m_dist_next     = pend_d_reg;
                    m_flag_next     = pend_f_reg;
                    first_len_next  = '0;
                    second_len_next = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        rd_cnt_reg <= rd_cnt_next;
        pend_d_reg <= pend_d_next;
        pend_f_reg <= pend_f_next;
        m_dist_reg <= m_dist_next;
        m_flag_reg <= m_flag_next;
    end

    // ---------------------------------------------------------- first string
    ced_feed #(
        .MAX_LEN (MAX_LEN),
        .LW      (LW),
        .AW      (AW)
    ) u_feed (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr),
        .wr_addr  (first_len_reg[AW-1:0]),
        .wr_data  (s_tdata),
        .rd_en    (rd_en),
        .rd_addr  (rd_cnt_reg[AW-1:0]),
        .rd_last  (rd_last),
        .rd_row   (rd_cnt_reg + LW'(1)),
        .a_out    (a_w[0]),
        .v_out    (v_w[0]),
        .last_out (last_w[0]),
        .dn_out   (dn_w[0]),
        .do_out   (do_w[0])
    );

    // nothing enters the result path at the head of the chain
    assign res_v_w[0] = 1'b0;
    assign res_d_w[0] = '0;

    // ------------------------------------------------------------- cell chain
    // cell j holds character j of the second string and column j of the table
    for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
        ced_cell #(
            .LW  (LW),
            .COL (j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .init      (cell_init),
            .load_en   (cell_load),
            .load_ch   (s_tdata),
            .len       (second_len_reg),
            .a_in      (a_w[j-1]),
            .v_in      (v_w[j-1]),
            .last_in   (last_w[j-1]),
            .dn_in     (dn_w[j-1]),
            .do_in     (do_w[j-1]),
            .res_v_in  (res_v_w[j-1]),
            .res_d_in  (res_d_w[j-1]),
            .a_out     (a_w[j]),
            .v_out     (v_w[j]),
            .last_out  (last_w[j]),
            .dn_out    (dn_w[j]),
            .do_out    (do_w[j]),
            .res_v_out (res_v_w[j]),
            .res_d_out (res_d_w[j])
        );
    end

    // ----------------------------------------------------------------- output
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_dist_reg};
    assign m_tuser  = m_flag_reg;

endmodule

[tb/ced_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ced_checker : scoreboard for the case-insensitive edit distance engine
// Watches both channels, keeps its own copy of the two strings, works out
// the distance owed by each finish transfer and compares every result.
// ----------------------------------------------------------------------------
module ced_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [1:0] s_tuser,   // [1:0] mode
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [6:0] distance, [7] zero pad
    input  logic       m_tuser,   // [0] too_long
    output int         errors,
    output int         outstanding
);
    import ced_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              too_long;
    } dist_result_t;

    logic [CHAR_W-1:0] first_str  [MAX_LEN];
    logic [CHAR_W-1:0] second_str [MAX_LEN];
    int                first_cnt;
    int                second_cnt;
    bit                overflowed;
    dist_result_t      owed_distances [$];

    function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    // single-row Levenshtein sweep over the stored strings
    function automatic logic [DIST_W-1:0] sweep_rows();
        int                row [0:MAX_LEN];
        int                diag;
        int                up;
        int                best;
        logic [CHAR_W-1:0] a;
        for (int j = 0; j <= second_cnt; j++) begin
            row[j] = j;
        end
        for (int i = 1; i <= first_cnt; i++) begin
            diag   = row[0];
            row[0] = i;
            a      = lower_byte(first_str[i-1]);
            for (int j = 1; j <= second_cnt; j++) begin
                up   = row[j];
                best = up + 1;
                if (row[j-1] + 1 < best) best = row[j-1] + 1;
                if (diag + (a != lower_byte(second_str[j-1])) < best) begin
                    best = diag + (a != lower_byte(second_str[j-1]));
                end
                row[j] = best;
                diag   = up;
            end
        end
        best = row[second_cnt];
        if (best > TOO_LONG_DIST) best = TOO_LONG_DIST;
        return best[DIST_W-1:0];
    endfunction

    task automatic absorb_item(input logic [1:0] mode, input logic [CHAR_W-1:0] ch);
        dist_result_t r;
        case (mode)
            MODE_FIRST: begin
                if (first_cnt < MAX_LEN) begin
                    first_str[first_cnt] = ch;
                    first_cnt++;
                end else begin
                    overflowed = 1'b1;
                end
            end
            MODE_SECOND: begin
                if (second_cnt < MAX_LEN) begin
                    second_str[second_cnt] = ch;
                    second_cnt++;
                end else begin
                    overflowed = 1'b1;
                end
            end
            MODE_FINISH: begin
                r.too_long = overflowed;
                r.dist_val = overflowed ? DIST_W'(TOO_LONG_DIST) : sweep_rows();
                owed_distances.push_back(r);
                first_cnt  = 0;
                second_cnt = 0;
                overflowed = 1'b0;
            end
            default: ; // unused code, no effect
        endcase
    endtask

    task automatic check_result();
        dist_result_t exp;
        if (owed_distances.size() == 0) begin
            $display("%0t: unexpected result: distance %0d too_long %0b",
                     $time, m_tdata, m_tuser);
            errors++;
        end else begin
            exp = owed_distances.pop_front();
            if (m_tdata !== {{(8-DIST_W){1'b0}}, exp.dist_val}) begin
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, exp.dist_val, m_tdata);
                errors++;
            end
            if (m_tuser !== exp.too_long) begin
                $display("%0t: too_long mismatch: expected %0b, actual %0b",
                         $time, exp.too_long, m_tuser);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors     = 0;
            first_cnt  = 0;
            second_cnt = 0;
            overflowed = 1'b0;
            owed_distances.delete();
        end else begin
            if (s_tvalid && s_tready) absorb_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
        outstanding = owed_distances.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for the case-insensitive edit distance engine
// Drives string pairs and broken sequences into the input channel (a short
// directed set, then random pairs of mostly small sizes with some full and overflowing ones),
// stalls both channels in random bursts and leaves the checking to
// ced_checker, whose error count decides the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ced_pkg::*;

    localparam int          MAX_LEN      = 64;
    localparam int          ITEM_TARGET  = 1650;
    // last stretch of the run is driven with no idling on either side
    localparam int          QUIET_TAIL   = 200;
    // drain allowance for the worst sweep, padded
    localparam int          DRAIN_CYCLES = 2 * MAX_LEN + 20;
    // mode code the block must ignore
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;      // [7:0] ch
    logic [1:0] s_tuser;      // [1:0] mode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;      // [6:0] distance, [7] zero pad
    logic       m_tuser;      // [0] too_long

    int         errors;
    int         outstanding;
    int         items_sent;
    bit         gaps_on;      // sender idles in bursts when set
    bit         stalls_on;    // receiver stalls in bursts when set
    int         stall_left = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    case_insensitive_edit_distance_top #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ced_checker #(
        .MAX_LEN (MAX_LEN)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Result side back-pressure: stall bursts of random length starting at
    // any cycle, so stalls land on every phase of a result transfer.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Character source: biased towards a, b and c in both cases so that
    // matches and folded matches are common, with the odd arbitrary byte.
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 8'h61 + 8'($urandom_range(0, 2)) - ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        if (sel < 75) return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        if (sel < 85) begin
            // bytes just outside the letter ranges
            case ($urandom_range(0, 3))
                0:       return 8'h40;
                1:       return 8'h5B;
                2:       return 8'h60;
                default: return 8'h7B;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One input transfer: optional idle burst first, then hold until accepted.
    task automatic push(input logic [1:0] mode, input logic [7:0] ch);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    // A well-formed pair: appends to both strings interleaved at random,
    // occasional ignored codes mixed in, closed by a finish.
    task automatic send_pair(input int len_a, input int len_b);
        int a_left;
        int b_left;
        a_left = len_a;
        b_left = len_b;
        while (a_left > 0 || b_left > 0) begin
            if ($urandom_range(0, 29) == 0) push(MODE_UNUSED, pick_char());
            if (b_left == 0 || (a_left > 0 && $urandom_range(0, 1) == 0)) begin
                push(MODE_FIRST, pick_char());
                a_left--;
            end else begin
                push(MODE_SECOND, pick_char());
                b_left--;
            end
        end
        push(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Broken sequence: codes drawn at random, unused one included.
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            push(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int pair_idx;
        int sel;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = MODE_FIRST;
        items_sent = 0;
        gaps_on    = 1'b0;
        stalls_on  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --- directed: empties, byte extremes, fold edges, every code ---
        push(MODE_FINISH, 8'h00);                              // both empty
        push(MODE_FIRST, 8'h00);  push(MODE_FINISH, 8'h00);    // second empty
        push(MODE_SECOND, 8'hFF); push(MODE_FINISH, 8'h00);    // first empty
        push(MODE_FIRST, 8'h41);  push(MODE_SECOND, 8'h61);    // 'A' vs 'a'
        push(MODE_FINISH, 8'h00);
        push(MODE_FIRST, 8'h5A);  push(MODE_SECOND, 8'h7A);    // 'Z' vs 'z'
        push(MODE_UNUSED, 8'h55);                              // ignored
        push(MODE_FINISH, 8'h00);
        push(MODE_FIRST, 8'h40);  push(MODE_SECOND, 8'h60);    // '@' vs '`'
        push(MODE_FINISH, 8'h00);
        push(MODE_FIRST, 8'h5B);  push(MODE_SECOND, 8'h7B);    // '[' vs '{'
        push(MODE_FINISH, 8'h00);
        push(MODE_FIRST, 8'hFF);  push(MODE_FIRST, 8'h00);
        push(MODE_SECOND, 8'h00); push(MODE_SECOND, 8'hFF);
        push(MODE_FINISH, 8'hFF);                              // ch ignored

        // --- random pairs ---
        pair_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - QUIET_TAIL) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
            end
            sel = $urandom_range(0, 99);
            if (pair_idx == 0) begin
                send_pair(MAX_LEN, MAX_LEN);                   // both full
            end else if (pair_idx == 1 || (sel >= 88 && sel < 95)) begin
                // at least one string overruns its store
                if ($urandom_range(0, 1)) begin
                    send_pair(MAX_LEN + $urandom_range(1, 6), $urandom_range(0, 8));
                end else begin
                    send_pair($urandom_range(0, 8), MAX_LEN + $urandom_range(1, 6));
                end
            end else if (sel < 72) begin
                send_pair($urandom_range(0, 10), $urandom_range(0, 10));
            end else if (sel < 84) begin
                send_pair($urandom_range(0, 30), $urandom_range(0, 30));
            end else if (sel < 88) begin
                send_pair($urandom_range(40, MAX_LEN), $urandom_range(40, MAX_LEN));
            end else begin
                send_noise();
            end
            pair_idx++;
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain: nothing owed, then let any late result show up
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
